// ----- hw/rtl/bdq_pkg.sv -----
// Shared types and constants for the bounded double-ended queue.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package bdq_pkg;

  // Default geometry of the ring store
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Action codes carried by an input beat
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK       = 3'd4
  } action_t;

  // Status codes carried by a result beat
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Per-beat flags handed from the control unit to the result stage
  typedef struct packed {
    status_t status;
    logic    empty;
  } meta_t;

endpackage : bdq_pkg

`default_nettype wire

// ----- hw/rtl/bdq_ram.sv -----
// Ring store: one write port and two registered read ports with write bypass.
// Depends on bdq_pkg for default geometry; the top level sets the parameters.
`default_nettype none

module bdq_ram #(
  parameter int unsigned DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IDX_W     = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IDX_W-1:0]      wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  input  wire logic                  rd_en,
  input  wire logic [IDX_W-1:0]      rd_addr_front,
  input  wire logic [IDX_W-1:0]      rd_addr_back,
  output logic      [DATA_WIDTH-1:0] rd_front_r,
  output logic      [DATA_WIDTH-1:0] rd_back_r
);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];

  // Write the pushed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read both ends; take the entry written in the same cycle when addresses meet
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr_front)) begin
        rd_front_r <= wr_data;
      end else begin
        rd_front_r <= mem_r[rd_addr_front];
      end
      if (wr_en && (wr_addr == rd_addr_back)) begin
        rd_back_r <= wr_data;
      end else begin
        rd_back_r <= mem_r[rd_addr_back];
      end
    end
  end

endmodule : bdq_ram

`default_nettype wire

// ----- hw/rtl/bdq_ctrl.sv -----
// Head index and entry count of the ring, plus store addressing per action.
// Depends on bdq_pkg for action, status and flag types.
`default_nettype none

module bdq_ctrl #(
  parameter int unsigned DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IDX_W     = $clog2(DEPTH),
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [2:0]            action,
  input  wire logic [DATA_WIDTH-1:0] value,
  output logic                       wr_en,
  output logic      [IDX_W-1:0]      wr_addr,
  output logic      [DATA_WIDTH-1:0] wr_data,
  output logic      [IDX_W-1:0]      rd_addr_front,
  output logic      [IDX_W-1:0]      rd_addr_back,
  output logic      [CNT_W-1:0]      count_nxt,
  output bdq_pkg::meta_t             meta
);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] head_r;
  logic [IDX_W-1:0] head_nxt;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] back_off;
  logic             full;
  logic             empty_now;
  bdq_pkg::action_t act;

  // Add two ring positions, each below DEPTH, and fold back once
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign act       = bdq_pkg::action_t'(action);
  assign full      = (count_r == DEPTH_CNT);
  assign empty_now = (count_r == '0);
  assign wr_data   = value;

  // Decode the action into the new head, count and store write
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    wr_en       = 1'b0;
    wr_addr     = head_r;
    meta.status = bdq_pkg::ST_DONE;
    unique case (act)
      bdq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          meta.status = bdq_pkg::ST_OVERFLOW;
        end else begin
          head_nxt  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
          wr_en     = accept;
          wr_addr   = head_nxt;
          count_nxt = count_r + 1'b1;
        end
      end
      bdq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          meta.status = bdq_pkg::ST_OVERFLOW;
        end else begin
          wr_en     = accept;
          wr_addr   = ring_add(head_r, count_r[IDX_W-1:0]);
          count_nxt = count_r + 1'b1;
        end
      end
      bdq_pkg::ACT_POP_FRONT: begin
        if (empty_now) begin
          meta.status = bdq_pkg::ST_UNDERFLOW;
        end else begin
          head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      bdq_pkg::ACT_POP_BACK: begin
        if (empty_now) begin
          meta.status = bdq_pkg::ST_UNDERFLOW;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        // peek and unused codes leave the queue alone
      end
    endcase
    meta.empty = (count_nxt == '0);
  end

  // Address both ends of the queue as it stands after the action
  always_comb begin
    if (count_nxt == '0) begin
      back_off = '0;
    end else begin
      back_off = IDX_W'(count_nxt - 1'b1);
    end
  end

  assign rd_addr_front = head_nxt;
  assign rd_addr_back  = ring_add(head_nxt, back_off);

  // Advance ring state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule : bdq_ctrl

`default_nettype wire

// ----- hw/rtl/bdq_out.sv -----
// Read stage and result register with the valid/ready flow control.
// Depends on bdq_pkg for the status and flag types.
`default_nettype none

module bdq_out #(
  parameter int unsigned DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CNT_W-1:0]      count_nxt,
  input  wire bdq_pkg::meta_t        meta,
  input  wire logic [DATA_WIDTH-1:0] rd_front,
  input  wire logic [DATA_WIDTH-1:0] rd_back,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [DATA_WIDTH-1:0] out_front_value,
  output logic      [DATA_WIDTH-1:0] out_back_value,
  output logic      [CNT_W-1:0]      out_count,
  output logic                       out_empty_res,
  output logic      [1:0]            out_status
);

  logic           s1_valid_r;
  logic           s1_valid_nxt;
  bdq_pkg::meta_t s1_meta_r;
  logic [CNT_W-1:0] s1_count_r;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           s1_adv;
  logic           accept;

  // Move the read stage on whenever the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign s1_valid_nxt  = accept || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the beat's flags alongside the store read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r  <= meta;
      s1_count_r <= count_nxt;
    end
  end

  // Load the result register; an empty queue shows zero at both ends
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_front_value <= s1_meta_r.empty ? '0 : rd_front;
      out_back_value  <= s1_meta_r.empty ? '0 : rd_back;
      out_count       <= s1_count_r;
      out_empty_res   <= s1_meta_r.empty;
      out_status      <= s1_meta_r.status;
    end
  end

  assign out_valid = out_valid_r;

endmodule : bdq_out

`default_nettype wire

// ----- hw/rtl/bounded_deque.sv -----
// Top level of the bounded double-ended queue: control, ring store, result stage.
// Depends on bdq_pkg, bdq_ctrl, bdq_ram and bdq_out.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | in_action, in_value
//   out_    | output    | out_valid / out_ready | front/back value, count, empty, status
//
// One beat per cycle sustained while the output is not stalled; the store read
// registers as the input beat is taken, the result register loads when the read
// stage moves on, and a result can be taken once it sits in the result register.
// Reset (synchronous, rst_n low) clears head index, count and valid flags; the
// store is not cleared, since only written entries ever reach the result.
// A stalled output holds the result register and the read stage; input is
// taken while the read stage is empty or moving on.
`default_nettype none

module bounded_deque #(
  parameter int unsigned DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IDX_W     = $clog2(DEPTH),
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_action,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [DATA_WIDTH-1:0] out_front_value,
  output logic      [DATA_WIDTH-1:0] out_back_value,
  output logic      [CNT_W-1:0]      out_count,
  output logic                       out_empty_res,
  output logic      [1:0]            out_status
);

  logic                  accept;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]      rd_addr_front;
  logic [IDX_W-1:0]      rd_addr_back;
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_back;
  logic [CNT_W-1:0]      count_nxt;
  bdq_pkg::meta_t        meta;

  assign accept = in_valid && in_ready;

  bdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .action        (in_action),
    .value         (in_value),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr_front (rd_addr_front),
    .rd_addr_back  (rd_addr_back),
    .count_nxt     (count_nxt),
    .meta          (meta)
  );

  bdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk           (clk),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (accept),
    .rd_addr_front (rd_addr_front),
    .rd_addr_back  (rd_addr_back),
    .rd_front_r    (rd_front),
    .rd_back_r     (rd_back)
  );

  bdq_out #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .count_nxt       (count_nxt),
    .meta            (meta),
    .rd_front        (rd_front),
    .rd_back         (rd_back),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_empty_res   (out_empty_res),
    .out_status      (out_status)
  );

  // Count never passes capacity and the empty flag tracks it
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(DEPTH)) && (out_empty_res == (out_count == '0)))
    else $error("result count out of range or empty flag mismatch");

  // An overflow beat reports a full queue
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == bdq_pkg::ST_OVERFLOW)) |-> (out_count == CNT_W'(DEPTH)))
    else $error("overflow reported while queue not full");

  // An underflow beat reports an empty queue with zero at both ends
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == bdq_pkg::ST_UNDERFLOW))
      |-> out_empty_res && (out_front_value == '0) && (out_back_value == '0))
    else $error("underflow reported while queue holds entries");

  // A single-entry queue shows the same entry at both ends
  a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_count == CNT_W'(1))) |-> (out_front_value == out_back_value))
    else $error("front and back differ with one entry held");

endmodule : bounded_deque

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bounded_deque: a directed table of actions, then random traffic.
// Depends on bdq_pkg and the bounded_deque RTL; expected snapshots come from typed table rows or a local deque.

module testbench;

  localparam int unsigned DEPTH      = bdq_pkg::DEPTH_DEF;
  localparam int unsigned DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES     = 64;
  localparam int SETTLE_CYCLES       = 8;
  localparam int PHASE_ITEMS         = 100;
  localparam int GAP_PCT [4]         = '{0, 48, 0, 16};
  localparam int STALL_PCT [4]       = '{0, 0, 48, 16};

  // What the result channel reports after one action
  typedef struct packed {
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
    logic [CNT_W-1:0]      count;
    logic                  empty;
    bdq_pkg::status_t      status;
  } deque_snapshot_t;

  // One line of the directed table; typed rows carry their snapshot
  typedef struct packed {
    logic [2:0]            act;
    logic [DATA_WIDTH-1:0] val;
    logic [4:0]            reps;
    logic                  typed;
    deque_snapshot_t       want;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_action;
  logic [DATA_WIDTH-1:0] in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [DATA_WIDTH-1:0] out_front_value;
  logic [DATA_WIDTH-1:0] out_back_value;
  logic [CNT_W-1:0]      out_count;
  logic                  out_empty_res;
  logic [1:0]            out_status;

  // Local copy of the deque
  logic [DATA_WIDTH-1:0] ring_slots [DEPTH];
  logic [IDX_W-1:0]      head_slot;
  logic [CNT_W-1:0]      held_count;

  deque_snapshot_t deque_snapshots [$];
  int fault_count = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_done = 0;

  directed_row_t directed_rows [18] = '{
    '{bdq_pkg::ACT_PEEK,       32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_POP_FRONT,  32'hDEAD_BEEF, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, bdq_pkg::ST_UNDERFLOW}},
    '{bdq_pkg::ACT_POP_BACK,   32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, bdq_pkg::ST_UNDERFLOW}},
    '{3'd5,                    32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_PUSH_BACK,  32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_PUSH_FRONT, 32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_POP_BACK,   32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd1, 1'b0, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, bdq_pkg::ST_DONE}},
    '{3'd6,                    32'h5555_5555, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, bdq_pkg::ST_DONE}},
    '{3'd7,                    32'hAAAA_AAAA, 5'd1,  1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_PUSH_FRONT, 32'hA5A5_A5A5, 5'd1,  1'b1,
      '{32'hA5A5_A5A5, 32'hA5A5_A5A5, 5'd1, 1'b0, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_PUSH_BACK,  32'h8000_0001, 5'd14, 1'b0, '0},
    '{bdq_pkg::ACT_PUSH_FRONT, 32'h0000_0000, 5'd1,  1'b1,
      '{32'h0, 32'h8000_0001, 5'd16, 1'b0, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_PUSH_BACK,  32'h1234_5678, 5'd1,  1'b1,
      '{32'h0, 32'h8000_0001, 5'd16, 1'b0, bdq_pkg::ST_OVERFLOW}},
    '{bdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 32'h8000_0001, 5'd16, 1'b0, bdq_pkg::ST_OVERFLOW}},
    '{bdq_pkg::ACT_PEEK,       32'hFFFF_FFFF, 5'd1,  1'b1,
      '{32'h0, 32'h8000_0001, 5'd16, 1'b0, bdq_pkg::ST_DONE}},
    '{bdq_pkg::ACT_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, '0},
    '{bdq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, '0}
  };

  bounded_deque dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_empty_res   (out_empty_res),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one action to the local deque and return the snapshot after it
  function automatic deque_snapshot_t apply_deque_action(input logic [2:0] act,
                                                         input logic [DATA_WIDTH-1:0] val);
    deque_snapshot_t snap;
    logic [IDX_W-1:0] slot;
    snap = '0;
    snap.status = bdq_pkg::ST_DONE;
    case (act) inside
      bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
        if (held_count >= DEPTH) begin
          snap.status = bdq_pkg::ST_OVERFLOW;
        end else if (act == bdq_pkg::ACT_PUSH_FRONT) begin
          head_slot = head_slot - 1'b1;
          ring_slots[head_slot] = val;
          held_count = held_count + 1'b1;
        end else begin
          slot = head_slot + held_count[IDX_W-1:0];
          ring_slots[slot] = val;
          held_count = held_count + 1'b1;
        end
      end
      bdq_pkg::ACT_POP_FRONT, bdq_pkg::ACT_POP_BACK: begin
        if (held_count == 0) begin
          snap.status = bdq_pkg::ST_UNDERFLOW;
        end else begin
          if (act == bdq_pkg::ACT_POP_FRONT) head_slot = head_slot + 1'b1;
          held_count = held_count - 1'b1;
        end
      end
      default: ;
    endcase
    // Report both ends; a full ring wraps the back index through zero
    if (held_count != 0) begin
      slot = head_slot + held_count[IDX_W-1:0] - 1'b1;
      snap.front = ring_slots[head_slot];
      snap.back = ring_slots[slot];
    end
    snap.count = held_count;
    snap.empty = (held_count == 0);
    return snap;
  endfunction

  // Lean toward pushes or pops so the deque swings between full and empty
  function automatic logic [2:0] pick_action(input bit fill_bias);
    int roll;
    logic [2:0] act;
    roll = $urandom_range(99);
    if (roll < 6)
      act = 3'($urandom_range(7, 4));
    else if ((roll < 71) == fill_bias)
      act = 3'($urandom_range(1, 0));
    else
      act = 3'($urandom_range(3, 2));
    return act;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    logic [DATA_WIDTH-1:0] val;
    case ($urandom_range(7))
      0: val = '0;
      1: val = '1;
      default: val = DATA_WIDTH'($urandom());
    endcase
    return val;
  endfunction

  // Offer one beat, hold it until taken, then record the snapshot it should produce
  task automatic send_beat(input logic [2:0] act, input logic [DATA_WIDTH-1:0] val,
                           input bit typed, input deque_snapshot_t typed_want);
    deque_snapshot_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_deque_action(act, val);
    deque_snapshots.push_back(typed ? typed_want : predicted);
  endtask

  task automatic compare_field(input string field, input logic [DATA_WIDTH-1:0] want,
                               input logic [DATA_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fault_count++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each result beat against the oldest pending snapshot
  always @(posedge clk) begin
    deque_snapshot_t want;
    if (rst_n && out_valid && out_ready) begin
      if (deque_snapshots.size() == 0) begin
        $display("%0t: result beat with none pending, actual front %h back %h count %0d",
                 $time, out_front_value, out_back_value, out_count);
        fault_count++;
      end else begin
        want = deque_snapshots.pop_front();
        compare_field("front_value", want.front, out_front_value);
        compare_field("back_value", want.back, out_back_value);
        compare_field("count", want.count, out_count);
        compare_field("empty_res", want.empty, out_empty_res);
        compare_field("status", want.status, out_status);
      end
    end
  end

  // Stop a run that has gone quiet on both channels
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit fill_bias;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = bdq_pkg::ACT_PEEK;
    in_value  = '0;
    head_slot = '0;
    held_count = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_beat(directed_rows[r].act, directed_rows[r].val, directed_rows[r].typed,
                  directed_rows[r].want);
    end

    // Random traffic in phases of varying gaps and stalls; hold off the receiver once under full rate
    fill_bias = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = GAP_PCT[ph];
      recv_stall_pct = STALL_PCT[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 40) hold_req++;
        if (n % 30 == 0) fill_bias = ~fill_bias;
        send_beat(pick_action(fill_bias), pick_value(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep watching for stray beats before ending the run
    while (deque_snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- bounded_deque.f -----
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_out.sv
hw/rtl/bounded_deque.sv
dv/testbench.sv
